@@ hw/rtl/cdd_pkg.sv @@
// shared types and constants of the can command and config dispatcher
// no dependencies; used by the front, back and top level modules of the block

package cdd_pkg;

  localparam int unsigned COMMAND_DEPTH_DEF = 64;
  localparam int unsigned CONFIG_DEPTH_DEF  = 32;
  localparam int unsigned MID_DEPTH         = 2;
  localparam int unsigned OUT_DEPTH         = 2;

  localparam logic [10:0] COMMAND_FRAME_ID = 11'd1;
  localparam logic [3:0]  MAX_LENGTH       = 4'd8;

  localparam logic [10:0] NODE_ID_RST       = 11'd2;
  localparam logic [7:0]  VERIFY_KEY_RST    = 8'd0;
  localparam logic [7:0]  COMMAND_LIMIT_RST = 8'd32;
  localparam logic [7:0]  IDLE_COMMAND_RST  = 8'd0;

  typedef enum logic [1:0] {
    REG_NODE_ID,
    REG_VERIFY_KEY,
    REG_COMMAND_LIMIT,
    REG_IDLE_COMMAND
  } cfg_reg_t;

  typedef struct packed {
    logic [10:0] node_id;
    logic [7:0]  verify_key;
    logic [7:0]  command_limit;
    logic [7:0]  idle_command;
  } cfg_regs_t;

  typedef struct packed {
    logic        frame_present;
    logic [10:0] frame_ident;
    logic [3:0]  frame_length;
    logic [7:0]  payload_b0;
    logic [7:0]  payload_b1;
    logic [7:0]  payload_b2;
    logic [7:0]  payload_b3;
    logic [7:0]  payload_b4;
    logic [7:0]  payload_b5;
    logic [7:0]  payload_b6;
    logic [7:0]  payload_b7;
    logic        take_config;
  } poll_t;

  typedef struct packed {
    logic        command_frame_seen;
    logic [7:0]  current_command;
    logic        config_valid;
    logic [7:0]  config_target;
    logic [7:0]  config_setting;
    logic [31:0] config_value;
    logic        command_overflow;
    logic        config_overrun;
  } result_t;

  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  setting;
    logic [31:0] value;
  } cfg_entry_t;

  // classified poll handed from front to back
  typedef struct packed {
    logic            seen;
    logic [7:0]      cmd_mask;
    logic [7:0][7:0] bytes;
    logic            cfg_push;
    cfg_entry_t      entry;
    logic            take;
  } rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_CONFIG,
    BK_READ,
    BK_RESULT
  } back_state_t;

endpackage

@@ hw/rtl/cdd_ram.sv @@
// generic single write port ram with registered, enabled read
// no dependencies

module cdd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/cdd_queue.sv @@
// short flop based request queue with push/full and pop/empty sides
// no dependencies

module cdd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/cdd_front.sv @@
// front end: accepts polls and classifies command and config frames
// depends on cdd_pkg

module cdd_front (
  input  logic              push,
  input  cdd_pkg::poll_t    poll,
  input  cdd_pkg::cfg_regs_t regs,
  input  logic              mid_full,
  output logic              full,
  output logic              rec_push,
  output cdd_pkg::rec_t     rec
);

  import cdd_pkg::*;

  logic [3:0]      len;
  logic [7:0][7:0] b;
  logic            is_cmd;
  logic            is_cfg;
  logic [31:0]     value;

  assign full     = mid_full;
  assign rec_push = push && !mid_full;

  always_comb begin
    len = (poll.frame_length > MAX_LENGTH) ? MAX_LENGTH : poll.frame_length;
    b[0] = poll.payload_b0;
    b[1] = poll.payload_b1;
    b[2] = poll.payload_b2;
    b[3] = poll.payload_b3;
    b[4] = poll.payload_b4;
    b[5] = poll.payload_b5;
    b[6] = poll.payload_b6;
    b[7] = poll.payload_b7;

    is_cmd = poll.frame_present && (poll.frame_ident == COMMAND_FRAME_ID);
    is_cfg = poll.frame_present && !is_cmd && (poll.frame_ident == regs.node_id)
             && (b[0] == regs.verify_key) && (len > 4'd3);

    value = {24'd0, b[3]};
    if (len >= 4'd5) value[15:8]  = b[4];
    if (len >= 4'd6) value[23:16] = b[5];
    if (len >= 4'd7) value[31:24] = b[6];

    rec.seen  = is_cmd;
    rec.bytes = b;
    for (int i = 0; i < 8; i++) begin
      rec.cmd_mask[i] = is_cmd && (4'(i) < len) && (b[i] < regs.command_limit);
    end
    rec.cfg_push      = is_cfg;
    rec.entry.target  = b[1];
    rec.entry.setting = b[2];
    rec.entry.value   = value;
    rec.take          = poll.take_config;
  end

endmodule

@@ hw/rtl/cdd_back.sv @@
// back end: sequencer that fills the command store and config fifo,
// then reads both and builds one result; depends on cdd_pkg, cdd_ram

module cdd_back #(
  parameter int unsigned COMMAND_DEPTH = cdd_pkg::COMMAND_DEPTH_DEF,
  parameter int unsigned CONFIG_DEPTH  = cdd_pkg::CONFIG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_empty,
  input  cdd_pkg::rec_t     rec_in,
  output logic              rec_pop,
  input  logic [7:0]        idle_command,
  input  logic              res_full,
  output logic              res_push,
  output cdd_pkg::result_t  res
);

  import cdd_pkg::*;

  localparam int unsigned CAW = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
  localparam int unsigned CIW = $clog2(COMMAND_DEPTH + 1);
  localparam int unsigned FAW = (CONFIG_DEPTH > 1) ? $clog2(CONFIG_DEPTH) : 1;
  localparam int unsigned FCW = $clog2(CONFIG_DEPTH + 1);

  back_state_t    state, state_next;
  rec_t           rec, rec_next;
  logic [2:0]     byte_idx, byte_idx_next;
  logic [CIW-1:0] write_index, write_index_next;
  logic [CIW-1:0] read_index, read_index_next;
  logic [FAW-1:0] fifo_head, fifo_head_next;
  logic [FCW-1:0] fifo_count, fifo_count_next;
  logic           cmd_ovf, cmd_ovf_next;
  logic           cfg_ovr, cfg_ovr_next;
  logic           have_cmd, have_cmd_next;
  logic           pop_cfg, pop_cfg_next;

  logic           cmd_we;
  logic [7:0]     cmd_rdata;
  logic           cfg_we;
  logic [FCW:0]   slot_sum;
  logic [FAW-1:0] cfg_waddr;
  logic [47:0]    cfg_rdata;
  cfg_entry_t     cfg_out;
  logic           rd_en;

  cdd_ram #(.WIDTH(8), .DEPTH(COMMAND_DEPTH)) u_cmd_ram (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (write_index[CAW-1:0]),
    .wdata (rec.bytes[byte_idx]),
    .re    (rd_en),
    .raddr (read_index[CAW-1:0]),
    .rdata (cmd_rdata)
  );

  cdd_ram #(.WIDTH(48), .DEPTH(CONFIG_DEPTH)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cfg_waddr),
    .wdata (rec.entry),
    .re    (rd_en),
    .raddr (fifo_head),
    .rdata (cfg_rdata)
  );

  assign cfg_out  = cfg_rdata;
  assign slot_sum = (FCW + 1)'(fifo_head) + (FCW + 1)'(fifo_count);
  assign cfg_waddr = (slot_sum >= (FCW + 1)'(CONFIG_DEPTH))
                     ? FAW'(slot_sum - (FCW + 1)'(CONFIG_DEPTH)) : FAW'(slot_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      write_index <= '0;
      read_index  <= '0;
      fifo_head   <= '0;
      fifo_count  <= '0;
      byte_idx    <= '0;
      cmd_ovf     <= 1'b0;
      cfg_ovr     <= 1'b0;
      have_cmd    <= 1'b0;
      pop_cfg     <= 1'b0;
    end else begin
      state       <= state_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      fifo_head   <= fifo_head_next;
      fifo_count  <= fifo_count_next;
      byte_idx    <= byte_idx_next;
      cmd_ovf     <= cmd_ovf_next;
      cfg_ovr     <= cfg_ovr_next;
      have_cmd    <= have_cmd_next;
      pop_cfg     <= pop_cfg_next;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

  always_comb begin
    state_next       = state;
    rec_next         = rec;
    byte_idx_next    = byte_idx;
    write_index_next = write_index;
    read_index_next  = read_index;
    fifo_head_next   = fifo_head;
    fifo_count_next  = fifo_count;
    cmd_ovf_next     = cmd_ovf;
    cfg_ovr_next     = cfg_ovr;
    have_cmd_next    = have_cmd;
    pop_cfg_next     = pop_cfg;
    rec_pop          = 1'b0;
    cmd_we           = 1'b0;
    cfg_we           = 1'b0;
    rd_en            = 1'b0;
    res_push         = 1'b0;
    res              = '0;

    unique case (state)
      BK_IDLE: begin
        if (!rec_empty) begin
          rec_pop       = 1'b1;
          rec_next      = rec_in;
          byte_idx_next = '0;
          cmd_ovf_next  = 1'b0;
          cfg_ovr_next  = 1'b0;
          state_next    = (rec_in.cmd_mask != '0) ? BK_WRITE : BK_CONFIG;
        end
      end
      // one command byte per cycle
      BK_WRITE: begin
        if (rec.cmd_mask[byte_idx]) begin
          if (write_index < CIW'(COMMAND_DEPTH)) begin
            cmd_we           = 1'b1;
            write_index_next = write_index + 1'b1;
          end else begin
            cmd_ovf_next = 1'b1;
          end
        end
        byte_idx_next = byte_idx + 1'b1;
        if (byte_idx == 3'd7) begin
          state_next = BK_CONFIG;
        end
      end
      BK_CONFIG: begin
        if (rec.cfg_push) begin
          if (fifo_count < FCW'(CONFIG_DEPTH)) begin
            cfg_we          = 1'b1;
            fifo_count_next = fifo_count + 1'b1;
          end else begin
            cfg_ovr_next = 1'b1;
          end
        end
        state_next = BK_READ;
      end
      BK_READ: begin
        rd_en = 1'b1;
        if (read_index < write_index) begin
          have_cmd_next   = 1'b1;
          read_index_next = read_index + 1'b1;
        end else begin
          have_cmd_next    = 1'b0;
          read_index_next  = '0;
          write_index_next = '0;
        end
        pop_cfg_next = rec.take && (fifo_count != '0);
        if (rec.take && (fifo_count != '0)) begin
          fifo_head_next  = (fifo_head == FAW'(CONFIG_DEPTH - 1)) ? '0 : fifo_head + 1'b1;
          fifo_count_next = fifo_count - 1'b1;
        end
        state_next = BK_RESULT;
      end
      BK_RESULT: begin
        res.command_frame_seen = rec.seen;
        res.current_command    = have_cmd ? cmd_rdata : idle_command;
        res.config_valid       = pop_cfg;
        res.config_target      = pop_cfg ? cfg_out.target : 8'd0;
        res.config_setting     = pop_cfg ? cfg_out.setting : 8'd0;
        res.config_value       = pop_cfg ? cfg_out.value : 32'd0;
        res.command_overflow   = cmd_ovf;
        res.config_overrun     = cfg_ovr;
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/can_command_and_config_dispatcher.sv @@
// top level of the can command and config dispatcher: config registers,
// front classifier, mid queue, back sequencer and result queue
// depends on cdd_pkg, cdd_front, cdd_queue, cdd_back
//
// usage: each poll (one optional can frame plus an optional config pop
// request) is pushed with push while full is low. exactly one result per
// poll appears at the result port in order; it is valid while empty is low
// and taken with pop. registers are written through cfg_we/cfg_index/cfg_data
// while no poll is in flight.
// the back sequencer handles one poll at a time. a poll with command bytes
// passes through the write state, where the command store is written one
// payload byte per cycle over all eight byte slots; a poll without command
// bytes goes straight to the config state. the front accepts up to two polls
// ahead into the mid queue while the back is busy.
// reset clears the indices, the fifo head and count, both queues and restores
// register defaults; store contents are not cleared. when the receiver stops
// popping, the result queue fills, the back halts, and then full rises.

module can_command_and_config_dispatcher #(
  parameter int unsigned COMMAND_DEPTH = cdd_pkg::COMMAND_DEPTH_DEF,
  parameter int unsigned CONFIG_DEPTH  = cdd_pkg::CONFIG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cdd_pkg::poll_t    poll,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output cdd_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [10:0]       cfg_data
);

  import cdd_pkg::*;

  cfg_regs_t regs;
  logic      mid_full;
  logic      mid_empty;
  logic      mid_push;
  logic      mid_pop;
  rec_t      mid_wdata;
  rec_t      mid_rdata;
  logic      res_push;
  logic      res_full;
  result_t   res_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.node_id       <= NODE_ID_RST;
      regs.verify_key    <= VERIFY_KEY_RST;
      regs.command_limit <= COMMAND_LIMIT_RST;
      regs.idle_command  <= IDLE_COMMAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODE_ID:       regs.node_id       <= cfg_data;
        REG_VERIFY_KEY:    regs.verify_key    <= cfg_data[7:0];
        REG_COMMAND_LIMIT: regs.command_limit <= cfg_data[7:0];
        REG_IDLE_COMMAND:  regs.idle_command  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  cdd_front u_front (
    .push     (push),
    .poll     (poll),
    .regs     (regs),
    .mid_full (mid_full),
    .full     (full),
    .rec_push (mid_push),
    .rec      (mid_wdata)
  );

  cdd_queue #(.WIDTH($bits(rec_t)), .DEPTH(MID_DEPTH)) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  cdd_back #(.COMMAND_DEPTH(COMMAND_DEPTH), .CONFIG_DEPTH(CONFIG_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_empty    (mid_empty),
    .rec_in       (mid_rdata),
    .rec_pop      (mid_pop),
    .idle_command (regs.idle_command),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res_wdata)
  );

  cdd_queue #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("back pushed a result into a full result queue");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  a_no_cfg_fields_without_pop: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.config_valid) |-> (result.config_value == 32'd0
      && result.config_target == 8'd0 && result.config_setting == 8'd0))
    else $error("config fields set without a popped entry");

  a_pop_only_from_mid: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("back took a request from an empty mid queue");

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for can_command_and_config_dispatcher
// drives polls via the request queue, checks every result vs. a predictor or a typed row
// depends on cdd_pkg and the dispatcher rtl
`timescale 1ns / 1ps

module tb_top;
  import cdd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_POLLS    = 210;
  localparam int NUM_PHASES     = 6;

  typedef enum int {
    MIX_NORMAL,
    MIX_CONFIG_BURST,
    MIX_COMMAND_BURST,
    MIX_DRAIN
  } poll_mix_t;

  typedef struct packed {
    poll_t   p;
    logic    typed;
    result_t r;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  poll_t       poll;
  logic        full;
  logic        empty;
  logic        pop;
  result_t     result;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  logic        row_typed;
  result_t     row_exp;
  bit          calm;

  cfg_regs_t   model_regs;
  logic [7:0]  model_store [COMMAND_DEPTH_DEF];
  int unsigned model_wr;
  int unsigned model_rd;
  cfg_entry_t  model_fifo [$];

  result_t     pending_results [$];
  stim_row_t   directed_rows [$];

  int          n_accepted;
  int          n_popped;
  int          n_errors;
  int          n_overflows;
  int          n_overruns;
  int          n_config_pops;
  int          stall_cycles;

  can_command_and_config_dispatcher uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .poll      (poll),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic poll_t mk_poll(bit pres, logic [10:0] id, logic [3:0] len,
                                    logic [63:0] data, bit take);
    poll_t p;
    p.frame_present = pres;
    p.frame_ident   = id;
    p.frame_length  = len;
    p.payload_b0    = data[7:0];
    p.payload_b1    = data[15:8];
    p.payload_b2    = data[23:16];
    p.payload_b3    = data[31:24];
    p.payload_b4    = data[39:32];
    p.payload_b5    = data[47:40];
    p.payload_b6    = data[55:48];
    p.payload_b7    = data[63:56];
    p.take_config   = take;
    return p;
  endfunction

  function automatic result_t mk_cmd_result(bit seen, logic [7:0] cmd);
    result_t r;
    r = '0;
    r.command_frame_seen = seen;
    r.current_command    = cmd;
    return r;
  endfunction

  // frame handling first, then the command output, then the config pop
  function automatic result_t dispatch_poll(poll_t p);
    result_t     r;
    logic [7:0]  b [8];
    int unsigned len;
    logic [31:0] v;
    cfg_entry_t  e;
    r = '0;
    b[0] = p.payload_b0; b[1] = p.payload_b1; b[2] = p.payload_b2; b[3] = p.payload_b3;
    b[4] = p.payload_b4; b[5] = p.payload_b5; b[6] = p.payload_b6; b[7] = p.payload_b7;
    len = (p.frame_length > MAX_LENGTH) ? MAX_LENGTH : p.frame_length;
    if (p.frame_present) begin
      if (p.frame_ident == COMMAND_FRAME_ID) begin
        r.command_frame_seen = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (b[i] < model_regs.command_limit) begin
            if (model_wr < COMMAND_DEPTH_DEF) begin
              model_store[model_wr] = b[i];
              model_wr++;
            end else begin
              r.command_overflow = 1'b1;
            end
          end
        end
      end else if (p.frame_ident == model_regs.node_id &&
                   b[0] == model_regs.verify_key && len > 3) begin
        v = {24'h0, b[3]};
        if (len >= 5) v[15:8]  = b[4];
        if (len >= 6) v[23:16] = b[5];
        if (len >= 7) v[31:24] = b[6];
        e.target  = b[1];
        e.setting = b[2];
        e.value   = v;
        if (model_fifo.size() >= CONFIG_DEPTH_DEF) r.config_overrun = 1'b1;
        else model_fifo.insert(model_fifo.size(), e);
      end
    end
    if (model_rd < model_wr) begin
      r.current_command = model_store[model_rd];
      model_rd++;
    end else begin
      model_rd = 0;
      model_wr = 0;
      r.current_command = model_regs.idle_command;
    end
    if (p.take_config && model_fifo.size() > 0) begin
      e = model_fifo.pop_front();
      r.config_valid   = 1'b1;
      r.config_target  = e.target;
      r.config_setting = e.setting;
      r.config_value   = e.value;
    end
    return r;
  endfunction

  function automatic poll_t random_poll(poll_mix_t mix);
    int          kind;
    int          cmd_pct;
    int          cfg_pct;
    int          take_pct;
    logic [63:0] data;
    logic [3:0]  len;
    bit          take;
    data = {$urandom, $urandom};
    len  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    case (mix)
      MIX_CONFIG_BURST: begin
        cmd_pct = 5;  cfg_pct = 80; take_pct = 3;
      end
      MIX_COMMAND_BURST: begin
        cmd_pct = 85; cfg_pct = 5;  take_pct = 50;
      end
      MIX_DRAIN: begin
        cmd_pct = 10; cfg_pct = 20; take_pct = 90;
      end
      default: begin
        cmd_pct = 35; cfg_pct = 35; take_pct = 50;
      end
    endcase
    take = ($urandom_range(0, 99) < take_pct);
    kind = $urandom_range(0, 99);
    if (kind < cmd_pct) begin
      for (int i = 0; i < 8; i++) begin
        if (model_regs.command_limit != 0 && $urandom_range(0, 3) != 0)
          data[i*8 +: 8] = 8'($urandom_range(0, model_regs.command_limit - 1));
      end
      return mk_poll(1'b1, COMMAND_FRAME_ID, len, data, take);
    end
    if (kind < cmd_pct + cfg_pct) begin
      if ($urandom_range(0, 7) != 0) data[7:0] = model_regs.verify_key;
      if ($urandom_range(0, 7) != 0) len = 4'($urandom_range(4, 8));
      return mk_poll(1'b1, model_regs.node_id, len, data, take);
    end
    if (kind < cmd_pct + cfg_pct + (100 - cmd_pct - cfg_pct) / 2)
      return mk_poll(1'b1, 11'($urandom_range(0, 2047)), len, data, take);
    return mk_poll(1'b0, 11'($urandom_range(0, 2047)), 4'($urandom_range(0, 15)), data, take);
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h (result %0d)",
                                name, got, want, n_popped));
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t r;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no pending request");
      end else begin
        want = pending_results.pop_front();
        check_field("command_frame_seen", result.command_frame_seen, want.command_frame_seen);
        check_field("current_command", result.current_command, want.current_command);
        check_field("config_valid", result.config_valid, want.config_valid);
        check_field("config_target", result.config_target, want.config_target);
        check_field("config_setting", result.config_setting, want.config_setting);
        check_field("config_value", result.config_value, want.config_value);
        check_field("command_overflow", result.command_overflow, want.command_overflow);
        check_field("config_overrun", result.config_overrun, want.config_overrun);
      end
      n_popped++;
    end
    if (!rst && push && !full) begin
      r = dispatch_poll(poll);
      if (row_typed) r = row_exp;
      n_overflows   += r.command_overflow;
      n_overruns    += r.config_overrun;
      n_config_pops += r.config_valid;
      pending_results.insert(pending_results.size(), r);
      n_accepted++;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int gap;
    int mark;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
        pop <= 1'b0;
        @(negedge clk);
      end
      pop <= 1'b1;
      mark = n_popped;
      do @(negedge clk); while (n_popped == mark);
    end
  end

  task automatic send_poll(poll_t p, logic typed, result_t exp);
    int gap;
    int mark;
    gap = calm ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    poll      <= p;
    row_typed <= typed;
    row_exp   <= exp;
    mark = n_accepted;
    do @(negedge clk); while (n_accepted == mark);
  endtask

  task automatic wait_idle(int settle);
    push <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [10:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_NODE_ID:       model_regs.node_id       = data;
      REG_VERIFY_KEY:    model_regs.verify_key    = data[7:0];
      REG_COMMAND_LIMIT: model_regs.command_limit = data[7:0];
      REG_IDLE_COMMAND:  model_regs.idle_command  = data[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [10:0] node, logic [10:0] key, logic [10:0] limit,
                               logic [10:0] idle);
    write_reg(REG_NODE_ID, node);
    write_reg(REG_VERIFY_KEY, key);
    write_reg(REG_COMMAND_LIMIT, limit);
    write_reg(REG_IDLE_COMMAND, idle);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_row(poll_t p, logic typed, result_t r);
    stim_row_t row;
    row.p     = p;
    row.typed = typed;
    row.r     = r;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic load_directed_rows();
    result_t zero;
    zero = '0;
    add_row(mk_poll(1'b0, 11'd0, 4'd0, 64'h0, 1'b0), 1'b1, zero);
    add_row(mk_poll(1'b0, 11'd0, 4'd0, 64'h0, 1'b1), 1'b1, zero);
    add_row(mk_poll(1'b0, 11'd1, 4'd15, {8{8'hFF}}, 1'b0), 1'b1, zero);
    add_row(mk_poll(1'b1, 11'd1, 4'd3, 64'h0000_0000_0020_1F05, 1'b0),
            1'b1, mk_cmd_result(1'b1, 8'h05));
    add_row(mk_poll(1'b0, 11'd0, 4'd0, 64'h0, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b0, 11'd0, 4'd0, 64'h0, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd1, 4'd8, 64'h0, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd1, 4'd8, {8{8'hFF}}, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd1, 4'd0, 64'h0102_0304_0506_0708, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd1, 4'd15, 64'h0807_0605_0403_0201, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd4, 64'h0000_0000_7E55_AA00, 1'b1), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd5, 64'h0000_0044_3322_1100, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd6, 64'h0000_6655_4433_2200, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd7, 64'h0077_6655_4433_2200, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd8, 64'hFFFF_FFFF_FFFF_FF00, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd15, 64'hEEDD_CCBB_AA99_8800, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd3, 64'h0000_0000_0033_2200, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd8, 64'h1111_1111_1111_1101, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'h7FF, 4'd8, 64'h0, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd0, 4'd8, 64'h0, 1'b0), 1'b0, zero);
    add_row(mk_poll(1'b0, 11'd0, 4'd0, 64'h0, 1'b1), 1'b0, zero);
    add_row(mk_poll(1'b1, 11'd2, 4'd4, 64'h0000_0000_0102_0300, 1'b1), 1'b0, zero);
    repeat (5) add_row(mk_poll(1'b0, 11'd0, 4'd0, 64'h0, 1'b1), 1'b0, zero);
  endtask

  initial begin
    poll_mix_t mix;
    rst       = 1'b1;
    push      = 1'b0;
    poll      = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_NODE_ID;
    cfg_data  = '0;
    row_typed = 1'b0;
    row_exp   = '0;
    calm      = 1'b0;
    mix       = MIX_NORMAL;
    model_regs = {NODE_ID_RST, VERIFY_KEY_RST, COMMAND_LIMIT_RST, IDLE_COMMAND_RST};
    model_wr  = 0;
    model_rd  = 0;
    load_directed_rows();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_poll(directed_rows[i].p, directed_rows[i].typed, directed_rows[i].r);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle(16);
      case (ph)
        0: apply_setting(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
        1: apply_setting(11'd0, 11'd0, 11'd1, 11'd0);
        2: apply_setting(11'd1, 11'h03C, 11'h040, 11'h0A5);
        3: apply_setting(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), 11'h700,
                         11'($urandom_range(0, 2047)));
        4: apply_setting(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                         11'($urandom_range(1, 255)), 11'($urandom_range(0, 2047)));
        default: apply_setting(NODE_ID_RST, 11'(VERIFY_KEY_RST), 11'(COMMAND_LIMIT_RST),
                               11'(IDLE_COMMAND_RST));
      endcase
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if (n % 40 == 0) begin
          mix  = poll_mix_t'($urandom_range(0, 3));
          calm = ($urandom_range(0, 3) == 0);
        end
        send_poll(random_poll(mix), 1'b0, '0);
      end
    end

    wait_idle(24);
    $display("%0d polls sent over %0d register settings, %0d results checked",
             n_accepted, NUM_PHASES + 1, n_popped);
    $display("%0d config entries popped, %0d command overflows, %0d config overruns",
             n_config_pops, n_overflows, n_overruns);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
